/* src/wrm_pkg.sv */
// Package for the weighted running mean block: field widths, status and
// mode codes, controller states and the divider status bundle.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package wrm_pkg;

  localparam int SAMPLE_W  = 16;              // Q8.8 input item
  localparam int MEAN_W    = 32;              // Q16.16 result
  localparam int OUT_FRAC  = 16;              // fractional bits of the result
  localparam int SUM_W     = 64;              // weighted sum accumulator
  localparam int WT_W      = 32;              // weight total accumulator
  localparam int MUL_A_W   = 32;              // serial multiplier, multiplicand
  localparam int MUL_B_W   = 16;              // serial multiplier, multiplier
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int QUO_W     = SUM_W + 1;       // quotient with one guard bit
  localparam int ROOT_W    = SUM_W / 2;
  localparam int DIV_CNT_W = 7;               // divider step counter, wide enough for SUM_W plus the scaling shift

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_WT  = 2'd1;
  localparam logic [1:0] STAT_NEG_ROOT = 2'd2;
  localparam logic [1:0] STAT_SAT      = 2'd3;

  localparam logic KIND_ARITH = 1'b0;
  localparam logic KIND_QUAD  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic done;   // one-cycle pulse, quotient valid
    logic big;    // quotient overflowed the guard bit
  } div_stat_t;

endpackage

`default_nettype wire

/* src/weighted_running_mean.sv */
// Top level of the weighted running mean: controller, saturating sums and
// output register. Instantiates wrm_mul, wrm_div and wrm_sqrt; imports wrm_pkg.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_sample_value (Q8.8, value then weight)
//   out     | output    | out_valid/out_stall| out_mean_value (Q16.16), out_status
//   cfg     | input     | cfg_valid/cfg_ready| cfg_mean_kind
//
// A value transaction is only stored. A weight transaction runs one serial
// multiply in arithmetic mode and two in quadratic mode, then the divider at
// one quotient bit per cycle and, in quadratic mode, the square root unit at
// one root bit per cycle.
// Reset is synchronous and active low; it clears the sums and the mode.
// A finished result waits in the output register while out_stall holds;
// the next value transaction is taken meanwhile.
`default_nettype none

module weighted_running_mean
  import wrm_pkg::*;
#(
  parameter int FRAC_BITS = 8
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MEAN_W-1:0]   out_mean_value,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_mean_kind
);

  localparam int SHIFT_ARITH = OUT_FRAC - FRAC_BITS;
  localparam int SHIFT_QUAD  = 2 * OUT_FRAC - 2 * FRAC_BITS;
  localparam logic [DIV_CNT_W-1:0] STEPS_ARITH = DIV_CNT_W'(SUM_W + SHIFT_ARITH);
  localparam logic [DIV_CNT_W-1:0] STEPS_QUAD  = DIV_CNT_W'(SUM_W + SHIFT_QUAD);
  localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [WT_W-1:0]   WT_MAX   = {1'b0, {(WT_W-1){1'b1}}};
  localparam logic [WT_W-1:0]   WT_MIN   = {1'b1, {(WT_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  state_t state_r, state_nxt;

  logic                kind_r;
  logic                item_kind_r;
  logic                expect_r;
  logic [SAMPLE_W-1:0] pending_r;
  logic [SAMPLE_W-1:0] w_r;
  logic                sign_r;
  logic [SUM_W-1:0]    wsum_r;
  logic [WT_W-1:0]     wtot_r;
  logic                sat_r;
  logic                neg_r;
  logic [1:0]          pre_stat_r;
  logic                out_valid_r;
  logic [MEAN_W-1:0]   out_mean_r;
  logic [1:0]          out_status_r;

  logic                in_acc;
  logic [SAMPLE_W-1:0] in_bits;
  logic [SAMPLE_W-1:0] vmag;
  logic [SAMPLE_W-1:0] wmag_in;
  logic [SAMPLE_W-1:0] wmag_r;

  logic                mul_start;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                mul_done;
  logic [PROD_W-1:0]   prod;

  logic                div_start;
  logic [SUM_W-1:0]    nmag;
  logic [WT_W-1:0]     dmag;
  logic                neg;
  logic                neg_root;
  logic                wt_zero;
  logic [DIV_CNT_W-1:0] div_steps;
  div_stat_t           div_stat;
  logic [QUO_W-1:0]    quo;

  logic                sqrt_start;
  logic [SUM_W-1:0]    rad;
  logic                sqrt_done;
  logic [ROOT_W-1:0]   root;

  logic [PROD_W-1:0]   term;
  logic [SUM_W-1:0]    term_ext;
  logic [SUM_W-1:0]    sum_add;
  logic                sum_ovf;
  logic [WT_W-1:0]     w_ext;
  logic [WT_W-1:0]     wt_add;
  logic                wt_ovf;

  logic                rad_over;
  logic                clamp_n;
  logic                clamp_p;
  logic                fin_sat;
  logic [MEAN_W-1:0]   fin_mean;
  logic [1:0]          fin_stat;
  logic                out_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_bits   = in_sample_value;
  assign cfg_ready = 1'b1;

  assign vmag    = pending_r[SAMPLE_W-1] ? (~pending_r + 1'b1) : pending_r;
  assign wmag_in = in_bits[SAMPLE_W-1] ? (~in_bits + 1'b1) : in_bits;
  assign wmag_r  = w_r[SAMPLE_W-1] ? (~w_r + 1'b1) : w_r;

  // first pass squares the value in quadratic mode; second pass applies the weight
  assign mul_a = (state_r == ST_SQR) ? prod[MUL_A_W-1:0] : MUL_A_W'(vmag);
  assign mul_b = (state_r == ST_SQR) ? wmag_r :
                 ((kind_r == KIND_QUAD) ? vmag : wmag_in);

  wrm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // saturating accumulation
  assign term     = sign_r ? (~prod + 1'b1) : prod;
  assign term_ext = {{(SUM_W-PROD_W){term[PROD_W-1]}}, term};
  assign sum_add  = wsum_r + term_ext;
  assign sum_ovf  = (wsum_r[SUM_W-1] == term_ext[SUM_W-1]) &&
                    (sum_add[SUM_W-1] != wsum_r[SUM_W-1]);
  assign w_ext    = {{(WT_W-SAMPLE_W){w_r[SAMPLE_W-1]}}, w_r};
  assign wt_add   = wtot_r + w_ext;
  assign wt_ovf   = (wtot_r[WT_W-1] == w_ext[WT_W-1]) &&
                    (wt_add[WT_W-1] != wtot_r[WT_W-1]);

  // operands of the divider
  assign nmag      = wsum_r[SUM_W-1] ? (~wsum_r + 1'b1) : wsum_r;
  assign dmag      = wtot_r[WT_W-1] ? (~wtot_r + 1'b1) : wtot_r;
  assign neg       = wsum_r[SUM_W-1] ^ wtot_r[WT_W-1];
  assign wt_zero   = (wtot_r == '0);
  assign neg_root  = (item_kind_r == KIND_QUAD) && neg && (nmag != '0);
  assign div_steps = (item_kind_r == KIND_ARITH) ? STEPS_ARITH : STEPS_QUAD;

  wrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (nmag),
    .den   (dmag),
    .steps (div_steps),
    .stat  (div_stat),
    .quo   (quo)
  );

  assign rad_over = div_stat.big | quo[QUO_W-1];
  assign rad      = rad_over ? '1 : quo[SUM_W-1:0];

  wrm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (rad),
    .done  (sqrt_done),
    .root  (root)
  );

  // clamp of the arithmetic quotient to the result range
  assign clamp_n = div_stat.big | (|quo[QUO_W-1:MEAN_W]) |
                   (quo[MEAN_W-1] & (|quo[MEAN_W-2:0]));
  assign clamp_p = div_stat.big | (|quo[QUO_W-1:MEAN_W-1]);

  always_comb begin
    fin_sat  = sat_r;
    fin_mean = '0;
    fin_stat = pre_stat_r;
    if (pre_stat_r == STAT_OK) begin
      if (item_kind_r == KIND_QUAD) begin
        fin_sat  = sat_r | rad_over | root[ROOT_W-1];
        fin_mean = root[ROOT_W-1] ? MEAN_MAX : MEAN_W'(root);
      end else if (neg_r) begin
        fin_sat  = sat_r | clamp_n;
        fin_mean = clamp_n ? MEAN_MIN : (~quo[MEAN_W-1:0] + 1'b1);
      end else begin
        fin_sat  = sat_r | clamp_p;
        fin_mean = clamp_p ? MEAN_MAX : quo[MEAN_W-1:0];
      end
      fin_stat = fin_sat ? STAT_SAT : STAT_OK;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && expect_r) begin
          mul_start = 1'b1;
          state_nxt = (kind_r == KIND_QUAD) ? ST_SQR : ST_MUL;
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (wt_zero || neg_root) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (item_kind_r == KIND_QUAD) begin
            sqrt_start = 1'b1;
            state_nxt  = ST_SQRT;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the result until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_ARITH;
      expect_r    <= 1'b0;
      pending_r   <= '0;
      wsum_r      <= '0;
      wtot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        kind_r <= cfg_mean_kind;
      end
      if (in_acc) begin
        expect_r <= !expect_r;
        if (!expect_r) begin
          pending_r <= in_bits;
        end
      end
      if (state_r == ST_ACC) begin
        wsum_r <= sum_ovf ? (wsum_r[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_add;
        wtot_r <= wt_ovf ? (wtot_r[WT_W-1] ? WT_MIN : WT_MAX) : wt_add;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && expect_r) begin
      w_r         <= in_bits;
      item_kind_r <= kind_r;
      // v*v*w carries only the sign of the weight
      sign_r      <= in_bits[SAMPLE_W-1] ^ ((kind_r == KIND_ARITH) & pending_r[SAMPLE_W-1]);
    end
    if (state_r == ST_ACC) begin
      sat_r <= sum_ovf | wt_ovf;
    end
    if (state_r == ST_PREP) begin
      neg_r      <= neg;
      pre_stat_r <= wt_zero ? STAT_ZERO_WT : (neg_root ? STAT_NEG_ROOT : STAT_OK);
    end
    if (out_load) begin
      out_mean_r   <= fin_mean;
      out_status_r <= fin_stat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

/* src/wrm_mul.sv */
// Bit-serial unsigned shift-add multiplier, multiplier bits MSB first.
// Uses widths from wrm_pkg; the product holds until the next start.
`default_nettype none

module wrm_mul
  import wrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [PROD_W-1:0]  acc_r;
  logic [PROD_W-1:0]  acc_nxt;

  assign acc_nxt = {acc_r[PROD_W-2:0], 1'b0} + (b_r[MUL_B_W-1] ? PROD_W'(a_r) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MUL_B_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[MUL_B_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

/* src/wrm_div.sv */
// Restoring bit-serial divider: numerator bits shift in MSB first, then
// zeros for the fixed-point scaling; one quotient bit per cycle.
// Uses widths and div_stat_t from wrm_pkg.
`default_nettype none

module wrm_div
  import wrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SUM_W-1:0]     num,
  input  logic [WT_W-1:0]      den,
  input  logic [DIV_CNT_W-1:0] steps,
  output div_stat_t            stat,
  output logic [QUO_W-1:0]     quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]     n_r;
  logic [WT_W-1:0]      d_r;
  logic [WT_W-1:0]      rem_r;
  logic [WT_W-1:0]      rem_nxt;
  logic [QUO_W-1:0]     q_r;
  logic                 big_r;
  logic [WT_W:0]        trial;
  logic [WT_W:0]        diff;
  logic                 ge;

  // remainder stays below the divisor, so one extra bit covers the shift
  assign trial   = {rem_r, n_r[SUM_W-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign diff    = trial - {1'b0, d_r};
  assign rem_nxt = ge ? diff[WT_W-1:0] : trial[WT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps - 1'b1;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      n_r   <= {n_r[SUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[QUO_W-2:0], ge};
      big_r <= big_r | q_r[QUO_W-1];   // sticky: a set bit about to drop off
    end
  end

  assign stat.done = done_r;
  assign stat.big  = big_r;
  assign quo       = q_r;

endmodule

`default_nettype wire

/* src/wrm_sqrt.sv */
// Digit-serial integer square root: two radicand bits per cycle, one root
// bit per cycle, floor of the exact root. Uses widths from wrm_pkg.
`default_nettype none

module wrm_sqrt
  import wrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 1;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  x_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  sub_v;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign trial   = {rem_r, x_r[SUM_W-1 -: 2]};
  assign sub_v   = {1'b0, root_r, 2'b01};
  assign ge      = trial >= sub_v;
  assign diff    = trial - sub_v;
  assign rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[SUM_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

/* src/wrm_checker.sv */
// Port-level checker for weighted_running_mean and the bind that attaches it.
// Imports wrm_pkg for the status codes and field widths.
`default_nettype none

module wrm_checker
  import wrm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MEAN_W-1:0] out_mean_value,
  input logic [1:0]        out_status
);

  logic in_acc;
  logic weight_next_r;

  assign in_acc = in_valid && !in_stall;

  // track whether the next input transaction is a weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_next_r <= 1'b0;
    end else if (in_acc) begin
      weight_next_r <= !weight_next_r;
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled right after reset");

  a_value_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !weight_next_r |=> !in_stall)
    else $error("value transaction stalled the input");

  a_weight_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && weight_next_r |=> in_stall)
    else $error("input not stalled while a weight is processed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_value) && $stable(out_status))
    else $error("stalled result changed or dropped");

  a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_ZERO_WT || out_status == STAT_NEG_ROOT)
      |-> out_mean_value == '0)
    else $error("nonzero mean with zero weight sum or negative radicand");

endmodule

bind weighted_running_mean wrm_checker u_wrm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_mean_value (out_mean_value),
  .out_status     (out_status)
);

`default_nettype wire

/* tb/sv/wrm_mean_checker.sv */
// Checker for weighted_running_mean: follows the input, result and mode channels,
// predicts mean and status for every weight transaction and compares them in order.
// Depends on wrm_pkg for field widths and the status and mode codes.
module wrm_mean_checker
  import wrm_pkg::*;
#(
  parameter int FRAC_BITS = 8
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [MEAN_W-1:0]   out_mean_value,
  input  logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_mean_kind,
  output int                         fail_count,
  output int                         waiting_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [1:0]               status;
  } mean_result_t;

  logic                       kind = KIND_ARITH;
  logic signed [SAMPLE_W-1:0] held_value = '0;
  logic                       want_weight = 1'b0;
  logic signed [SUM_W-1:0]    acc_sum = '0;
  logic signed [WT_W-1:0]     wt_sum = '0;
  mean_result_t               means_due[$];
  int                         fails = 0;
  int                         waiting = 0;

  assign fail_count    = fails;
  assign waiting_count = waiting;

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  // Fold one weight into the sums and work out the mean it produces.
  task automatic fold_weight(input logic signed [SAMPLE_W-1:0] weight,
                             output mean_result_t res);
    logic signed [63:0] val64;
    logic signed [63:0] wt64;
    logic signed [63:0] term;
    logic signed [63:0] tot64;
    logic signed [64:0] sum_wide;
    logic signed [32:0] wt_wide;
    logic [63:0]        nmag;
    logic [63:0]        dmag;
    logic [63:0]        rad;
    logic [63:0]        root;
    logic [63:0]        quo64;
    logic [95:0]        num;
    logic [95:0]        quo;
    logic               neg;
    logic               sat;
    sat        = 1'b0;
    res.mean   = '0;
    res.status = STAT_OK;
    val64 = held_value;
    wt64  = weight;
    term  = (kind == KIND_QUAD) ? val64 * val64 * wt64 : val64 * wt64;

    sum_wide = acc_sum + term;
    if (sum_wide[64] != sum_wide[63]) begin
      acc_sum = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      sat = 1'b1;
    end else begin
      acc_sum = sum_wide[63:0];
    end
    wt_wide = wt_sum + weight;
    if (wt_wide[32] != wt_wide[31]) begin
      wt_sum = wt_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      sat = 1'b1;
    end else begin
      wt_sum = wt_wide[31:0];
    end

    if (wt_sum == 0) begin
      res.status = STAT_ZERO_WT;
    end else begin
      tot64 = wt_sum;
      nmag  = acc_sum[63] ? -acc_sum : acc_sum;
      dmag  = tot64[63] ? -tot64 : tot64;
      neg   = acc_sum[63] ^ wt_sum[WT_W-1];
      if (kind == KIND_QUAD) begin
        if (neg && nmag != 0) begin
          res.status = STAT_NEG_ROOT;
        end else begin
          num = {32'd0, nmag} << (32 - 2 * FRAC_BITS);
          quo = num / {32'd0, dmag};
          if (quo[95:64] != 0) begin
            rad = '1;
            sat = 1'b1;
          end else begin
            rad = quo[63:0];
          end
          root = floor_root(rad);
          if (root > 64'h7FFF_FFFF) begin
            root = 64'h7FFF_FFFF;
            sat = 1'b1;
          end
          res.mean = root[31:0];
        end
      end else begin
        num = {32'd0, nmag} << (16 - FRAC_BITS);
        quo = num / {32'd0, dmag};
        if (neg) begin
          if (quo > 96'h8000_0000) begin
            quo = 96'h8000_0000;
            sat = 1'b1;
          end
          quo64    = quo[63:0];
          res.mean = 32'(64'd0 - quo64);
        end else begin
          if (quo > 96'h7FFF_FFFF) begin
            quo = 96'h7FFF_FFFF;
            sat = 1'b1;
          end
          res.mean = quo[31:0];
        end
      end
      if (res.status == STAT_OK && sat) res.status = STAT_SAT;
    end
  endtask

  always @(posedge clk) begin
    int           errs;
    mean_result_t want;
    mean_result_t got;
    errs = 0;
    if (!rst_n) begin
      kind        = KIND_ARITH;
      held_value  = '0;
      want_weight = 1'b0;
      acc_sum     = '0;
      wt_sum      = '0;
      means_due.delete();
      waiting <= 0;
    end else begin
      if (cfg_valid && cfg_ready) kind = cfg_mean_kind;

      // Compare before taking new input: a result never belongs to a weight of this edge.
      if (out_valid && !out_stall) begin
        if (means_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got mean %0d status %0d",
                   $time, out_mean_value, out_status);
        end else begin
          want = means_due.pop_front();
          if (out_mean_value !== want.mean) begin
            errs++;
            $display("%0t: mean_value mismatch, expected %0d, got %0d",
                     $time, want.mean, out_mean_value);
          end
          if (out_status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (!want_weight) begin
          held_value  = in_sample_value;
          want_weight = 1'b1;
        end else begin
          want_weight = 1'b0;
          fold_weight(in_sample_value, got);
          means_due.push_back(got);
        end
      end
      waiting <= means_due.size();
    end
    fails <= fails + errs;
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the weighted_running_mean testbench: clock, reset, stimulus and verdict.
// Instantiates the block and wrm_mean_checker; takes codes and widths from wrm_pkg.
module testbench
  import wrm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS       = 8;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int PAIRS_PER_PHASE = 156;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [MEAN_W-1:0]   out_mean_value;
  logic [1:0]                 out_status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_mean_kind = KIND_ARITH;
  int                         fail_count;
  int                         waiting_count;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_left = 0;
  int          weight_track = 0;
  int unsigned cycle_count = 0;

  weighted_running_mean #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mean_value  (out_mean_value),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_mean_kind   (cfg_mean_kind)
  );

  wrm_mean_checker #(.FRAC_BITS(FRAC_BITS)) mean_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mean_value  (out_mean_value),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_mean_kind   (cfg_mean_kind),
    .fail_count      (fail_count),
    .waiting_count   (waiting_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weighted_running_mean regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls with occasional quiet stretches.
  always @(negedge clk) begin
    if (quiet_left != 0) begin
      quiet_left <= quiet_left - 1;
      out_stall  <= 1'b0;
    end else begin
      if ($urandom_range(63) == 0) quiet_left <= $urandom_range(40, 1);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_value <= sample;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] value,
                           input logic signed [SAMPLE_W-1:0] weight);
    send_sample(value);
    send_sample(weight);
    weight_track += weight;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting_count != 0) @(negedge clk);
  endtask

  // Change the mode only with the block idle; no value transaction is left without its weight.
  task automatic set_kind(input logic kind);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_mean_kind <= kind;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1:    return SAMPLE_W'($urandom);
      2:       return SAMPLE_W'(int'($urandom_range(1023)) - 512);
      default: begin
        case ($urandom_range(4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'sh0001;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  // Pull the weight total toward zero often, so zero sums and large means come up.
  function automatic logic signed [SAMPLE_W-1:0] pick_weight(input int total);
    int w;
    case ($urandom_range(3))
      0:       w = int'($urandom_range(65535)) - 32768;
      1:       w = int'($urandom_range(512)) - 256;
      2:       w = int'($urandom_range(8)) - 4 - total;
      default: w = (total > 0) ? -int'($urandom_range(32768)) : int'($urandom_range(32767));
    endcase
    if (w > 32767) w = 32767;
    else if (w < -32768) w = -32768;
    return w[SAMPLE_W-1:0];
  endfunction

  initial begin
    int   send_tab[4]  = '{0, 88, 0, 34};
    int   stall_tab[4] = '{0, 0, 88, 34};
    logic kind_tab[4]  = '{KIND_QUAD, KIND_ARITH, KIND_QUAD, KIND_ARITH};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Mode register starts out arithmetic.
    send_pair(16'sh0180, 16'sh0200);
    set_kind(KIND_QUAD);
    send_pair(16'sh0100, 16'sh0100);
    send_pair(16'sh4000, -16'sd1);        // negative mean of squares
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
    set_kind(KIND_ARITH);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);      // tiny weight total, large mean
    send_pair(16'sh0001, SAMPLE_W'(-weight_track));
    send_pair(16'sh0000, 16'sh0000);      // weight total stays zero
    send_pair(-16'sd1, 16'sh0003);
    send_pair(16'sh5555, 16'shAAAA);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_tab[phase];
      stall_pct     = stall_tab[phase];
      set_kind(kind_tab[phase]);
      for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
        if ($urandom_range(39) == 0) wait_drained();
        send_pair(pick_value(), pick_weight(weight_track));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("weighted_running_mean regression: pass");
    end else begin
      $display("weighted_running_mean regression: fail");
    end
    $finish;
  end

endmodule
